// ===== rtl/ccu_pkg.sv =====
// ccu_pkg: shared constants, controller state type and the command/status
// structs that join the coprime counter's controller and datapath.
// No dependencies.
package ccu_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int MAX_PRIMES_DEF = 9;

  // first trial divisor, and the first odd one after it
  localparam int FIRST_PRIME = 2;
  localparam int FIRST_ODD   = 3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FAC_START,
    ST_FAC_WAIT,
    ST_STRIP_START,
    ST_STRIP_WAIT,
    ST_LEFTOVER,
    ST_SUB_INIT,
    ST_SUB_TEST,
    ST_SUB_WAIT,
    ST_SUB_ACCUM,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic load;        // capture a new request
    logic div_fac;     // start divider: cofactor / trial divisor
    logic div_sub;     // start divider: running quotient / selected prime
    logic rec_prime;   // store trial divisor as a prime
    logic take_quot;   // cofactor <= quotient
    logic next_div;    // advance trial divisor
    logic rec_left;    // store leftover cofactor if above one
    logic sub_init;    // start a subset pass
    logic k_step;      // next prime index
    logic sub_quot;    // running quotient <= quotient, flip parity
    logic accum;       // add/subtract into excluded total, next subset
    logic set_result;  // load output register
  } cmd_t;

  typedef struct packed {
    logic zero;        // request had value zero
    logic div_busy;
    logic div_done;
    logic stop_loop;   // trial divisor exceeds cofactor / divisor
    logic rem_zero;
    logic bit_set;     // current subset holds prime k
    logic k_end;       // all primes of the subset visited
    logic subset_end;  // all non-empty subsets done
  } sts_t;

endpackage

// ===== rtl/ccu_in_if.sv =====
// ccu_in_if: request channel of the coprime counter (valid/ready + operands).
// No dependencies.
interface ccu_in_if #(
  parameter int DATA_WIDTH = 32
);
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] value_n;
  logic [DATA_WIDTH-1:0] upper_limit;

  modport source (output valid, output value_n, output upper_limit, input ready);
  modport sink   (input valid, input value_n, input upper_limit, output ready);
endinterface

// ===== rtl/ccu_out_if.sv =====
// ccu_out_if: result channel of the coprime counter (valid/ready + count).
// No dependencies.
interface ccu_out_if #(
  parameter int DATA_WIDTH = 32
);
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] coprime_total;

  modport source (output valid, output coprime_total, input ready);
  modport sink   (input valid, input coprime_total, output ready);
endinterface

// ===== rtl/ccu_divider.sv =====
// ccu_divider: restoring unsigned divider, one quotient bit per cycle.
// Depends on nothing; used by ccu_datapath.
module ccu_divider #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DATA_WIDTH-1:0] dividend,
  input  logic [DATA_WIDTH-1:0] divisor,
  output logic                  busy,
  output logic                  done,
  output logic [DATA_WIDTH-1:0] quotient,
  output logic [DATA_WIDTH-1:0] remainder
);
  localparam int CW = $clog2(DATA_WIDTH + 1);

  logic [DATA_WIDTH-1:0] rem_r, rem_nxt;
  logic [DATA_WIDTH-1:0] quo_r, quo_nxt;
  logic [DATA_WIDTH-1:0] dvs_r;
  logic [CW-1:0]         cnt_r;
  logic                  busy_r, done_r;
  logic [DATA_WIDTH:0]   shifted, diff;

  assign shifted = {rem_r, quo_r[DATA_WIDTH-1]};
  assign diff    = shifted - {1'b0, dvs_r};

  always_comb begin
    if (shifted >= {1'b0, dvs_r}) begin
      rem_nxt = diff[DATA_WIDTH-1:0];
      quo_nxt = {quo_r[DATA_WIDTH-2:0], 1'b1};
    end else begin
      rem_nxt = shifted[DATA_WIDTH-1:0];
      quo_nxt = {quo_r[DATA_WIDTH-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DATA_WIDTH);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign busy      = busy_r;
  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;
endmodule

// ===== rtl/ccu_datapath.sv =====
// ccu_datapath: operand, prime list and subset registers plus the shared divider.
// Depends on ccu_pkg and ccu_divider; driven by ccu_ctrl commands.
module ccu_datapath #(
  parameter int DATA_WIDTH = 32,
  parameter int MAX_PRIMES = 9
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ccu_pkg::cmd_t         cmd,
  output ccu_pkg::sts_t         sts,
  input  logic [DATA_WIDTH-1:0] value_n,
  input  logic [DATA_WIDTH-1:0] upper_limit,
  output logic [DATA_WIDTH-1:0] coprime_total
);
  import ccu_pkg::*;

  localparam int CNT_W = $clog2(MAX_PRIMES + 1);
  localparam int IDX_W = (MAX_PRIMES > 1) ? $clog2(MAX_PRIMES) : 1;

  logic [DATA_WIDTH-1:0] v_r, d_r, m_r, q_r, exc_r, res_r;
  logic                  zero_r, par_r;
  logic [DATA_WIDTH-1:0] prime_r [MAX_PRIMES];
  logic [CNT_W-1:0]      cnt_r, k_r;
  logic [MAX_PRIMES:0]   subset_r;

  logic                  div_start, div_busy, div_done;
  logic [DATA_WIDTH-1:0] div_a, div_b, div_q, div_rem;
  logic                  room;

  assign div_start = cmd.div_fac | cmd.div_sub;
  assign div_a     = cmd.div_sub ? q_r : v_r;
  assign div_b     = cmd.div_sub ? prime_r[k_r[IDX_W-1:0]] : d_r;
  assign room      = (cnt_r < CNT_W'(MAX_PRIMES));

  ccu_divider #(.DATA_WIDTH(DATA_WIDTH)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      v_r      <= value_n;
      m_r      <= upper_limit;
      zero_r   <= (value_n == '0);
      d_r      <= DATA_WIDTH'(FIRST_PRIME);
      cnt_r    <= '0;
      exc_r    <= '0;
      subset_r <= (MAX_PRIMES + 1)'(1);
    end else begin
      if (cmd.take_quot)
        v_r <= div_q;
      if (cmd.next_div)
        d_r <= (d_r == DATA_WIDTH'(FIRST_PRIME)) ? DATA_WIDTH'(FIRST_ODD)
                                                 : d_r + DATA_WIDTH'(2);
      if (cmd.rec_prime && room) begin
        prime_r[cnt_r[IDX_W-1:0]] <= d_r;
        cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.rec_left && room && (v_r > DATA_WIDTH'(1))) begin
        prime_r[cnt_r[IDX_W-1:0]] <= v_r;
        cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.accum) begin
        exc_r    <= par_r ? exc_r + q_r : exc_r - q_r;
        subset_r <= subset_r + 1'b1;
      end
    end
  end

  // one subset pass: q = m divided by each selected prime in turn
  always_ff @(posedge clk) begin
    if (cmd.sub_init) begin
      q_r   <= m_r;
      k_r   <= '0;
      par_r <= 1'b0;
    end else begin
      if (cmd.sub_quot) begin
        q_r   <= div_q;
        par_r <= ~par_r;
      end
      if (cmd.k_step)
        k_r <= k_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_result)
      res_r <= zero_r ? DATA_WIDTH'(m_r != '0) : m_r - exc_r;
  end

  always_comb begin
    sts.zero       = zero_r;
    sts.div_busy   = div_busy;
    sts.div_done   = div_done;
    sts.stop_loop  = (d_r != DATA_WIDTH'(FIRST_PRIME)) && (d_r > div_q);
    sts.rem_zero   = (div_rem == '0);
    sts.bit_set    = subset_r[k_r];
    sts.k_end      = (k_r == cnt_r);
    sts.subset_end = ((subset_r >> cnt_r) != '0);
  end

  assign coprime_total = res_r;
endmodule

// ===== rtl/ccu_ctrl.sv =====
// ccu_ctrl: sequencer for factoring and the subset sweep, plus output valid.
// Depends on ccu_pkg; commands ccu_datapath.
module ccu_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  ccu_pkg::sts_t sts,
  output ccu_pkg::cmd_t cmd
);
  import ccu_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:        if (in_valid) state_nxt = ST_FAC_START;
      ST_FAC_START:   state_nxt = sts.zero ? ST_RESULT : ST_FAC_WAIT;
      ST_FAC_WAIT: begin
        if (sts.div_done) begin
          if (sts.stop_loop)     state_nxt = ST_LEFTOVER;
          else if (sts.rem_zero) state_nxt = ST_STRIP_START;
          else                   state_nxt = ST_FAC_START;
        end
      end
      ST_STRIP_START: state_nxt = ST_STRIP_WAIT;
      ST_STRIP_WAIT: begin
        if (sts.div_done)
          state_nxt = sts.rem_zero ? ST_STRIP_START : ST_FAC_START;
      end
      ST_LEFTOVER:    state_nxt = ST_SUB_INIT;
      ST_SUB_INIT:    state_nxt = sts.subset_end ? ST_RESULT : ST_SUB_TEST;
      ST_SUB_TEST: begin
        if (sts.k_end)        state_nxt = ST_SUB_ACCUM;
        else if (sts.bit_set) state_nxt = ST_SUB_WAIT;
      end
      ST_SUB_WAIT:    if (sts.div_done) state_nxt = ST_SUB_TEST;
      ST_SUB_ACCUM:   state_nxt = ST_SUB_INIT;
      ST_RESULT:      if (slot_free) state_nxt = ST_IDLE;
      default:        state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      ST_IDLE:        cmd.load = in_valid;
      ST_FAC_START:   cmd.div_fac = !sts.zero;
      ST_FAC_WAIT: begin
        if (sts.div_done && !sts.stop_loop) begin
          cmd.rec_prime = sts.rem_zero;
          cmd.take_quot = sts.rem_zero;
          cmd.next_div  = !sts.rem_zero;
        end
      end
      ST_STRIP_START: cmd.div_fac = 1'b1;
      ST_STRIP_WAIT: begin
        if (sts.div_done) begin
          cmd.take_quot = sts.rem_zero;
          cmd.next_div  = !sts.rem_zero;
        end
      end
      ST_LEFTOVER:    cmd.rec_left = 1'b1;
      ST_SUB_INIT:    cmd.sub_init = !sts.subset_end;
      ST_SUB_TEST: begin
        if (!sts.k_end) begin
          cmd.div_sub = sts.bit_set;
          cmd.k_step  = !sts.bit_set;
        end
      end
      ST_SUB_WAIT: begin
        cmd.sub_quot = sts.div_done;
        cmd.k_step   = sts.div_done;
      end
      ST_SUB_ACCUM:   cmd.accum = 1'b1;
      ST_RESULT:      cmd.set_result = slot_free;
      default:        cmd = '0;
    endcase
  end

  always_comb begin
    if (cmd.set_result)
      out_valid_nxt = 1'b1;
    else if (out_ready)
      out_valid_nxt = 1'b0;
    else
      out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
endmodule

// ===== rtl/coprime_count_upto.sv =====
// coprime_count_upto: counts integers in 1..upper_limit coprime to value_n.
// Depends on ccu_pkg, ccu_in_if, ccu_out_if, ccu_ctrl, ccu_datapath.
//
// Usage:
//  - in_chan carries a request (value_n, upper_limit); it is taken when valid
//    and ready are both high. ready is high only while no request is in work.
//  - out_chan carries coprime_total, one per request, held in an output
//    register until taken; a new request is accepted while it waits.
//  - Method: primes of value_n by trial division (2, then odd d while
//    d*d <= cofactor), then each non-empty subset divides upper_limit by its
//    members in turn, quotients added or subtracted by subset size. One
//    restoring divider serves all divisions, one at a time. A 32-bit prime
//    value_n needs about 32768 trial divisors. value_n = 0 gives
//    (upper_limit >= 1).
//  - Only the first MAX_PRIMES distinct primes are used.
//  - Reset (rst_n low, synchronous) returns to idle and drops any result.
//  - If the receiver stalls, a finished result waits in its final state
//    until the output register frees up.
module coprime_count_upto #(
  parameter int DATA_WIDTH = ccu_pkg::DATA_WIDTH_DEF,
  parameter int MAX_PRIMES = ccu_pkg::MAX_PRIMES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  ccu_in_if.sink     in_chan,
  ccu_out_if.source  out_chan
);
  import ccu_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ccu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ccu_datapath #(
    .DATA_WIDTH (DATA_WIDTH),
    .MAX_PRIMES (MAX_PRIMES)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .value_n       (in_chan.value_n),
    .upper_limit   (in_chan.upper_limit),
    .coprime_total (out_chan.coprime_total)
  );

  // one request in work at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> !in_chan.ready)
    else $error("request accepted while another is in work");

  // a fresh result coincides with the return to idle
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_chan.valid) |-> in_chan.ready)
    else $error("result raised without returning to idle");

  // the shared divider is never restarted mid-division
  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_fac || cmd.div_sub) |-> !sts.div_busy)
    else $error("divider started while busy");
endmodule
